// ----- hw/rtl/ovlt_pkg.sv -----
// ----------------------------------------------------------------------------
// ovlt_pkg
// Types and codes shared by the ordered value list table and its cells.
// ----------------------------------------------------------------------------
package ovlt_pkg;

    // operation codes
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;
    localparam logic [1:0] KIND_UPDATE = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] key_value;
        logic signed [31:0] replacement;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] found_position;
        logic [8:0] entry_count;
    } t_out;

    // per-cell write command for the execute cycle
    typedef struct packed {
        logic write_key;
        logic write_repl;
        logic shift;
    } t_cell_cmd;

endpackage

// ----- hw/rtl/ordered_value_list_table_unit.sv -----
// ----------------------------------------------------------------------------
// ordered_value_list_table_unit
// Bounded ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// The cells compare at the accept edge; the execute state does the first-match pick
//   and the cell writes, and the result and its strobe are registered from it. A new
//   transaction is accepted only when the unit is not busy, that is, back in idle.
// Results are never stalled: each one is shown for exactly one cycle.
// Reset clears the entry count, busy and the strobe; entry contents stay
//   undefined and are never read before they are written.
module ordered_value_list_table_unit #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ovlt_pkg::t_in i_item,
    output logic          busy,
    output logic          o_valid,
    output ovlt_pkg::t_out o_result
);
    import ovlt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic          r_state, n_state;
    logic [1:0]    r_kind;
    logic [31:0]   r_key;
    logic [31:0]   r_repl;
    logic [CW-1:0] r_count, n_count;
    logic          r_valid;
    t_out          r_result, n_result;

    logic             accept;
    logic [31:0]      value [DEPTH];
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] first;
    logic [DEPTH-1:0] after;
    logic             any;
    logic [IW-1:0]    pos;
    t_cell_cmd        cmd [DEPTH];
    logic             exec;
    logic             full;
    logic             hit;

    assign accept = start && (r_state == ST_IDLE);
    assign exec   = (r_state == ST_EXEC);
    assign full   = (r_count == CW'(DEPTH));
    assign hit    = (r_count != '0) && any;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [31:0] next_value;
        if (g == DEPTH - 1) begin : g_last
            assign next_value = value[g];
        end else begin : g_mid
            assign next_value = value[g+1];
        end

        ovlt_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmp_en     (accept),
            .i_key        (i_item.key_value),
            .i_count      (r_count),
            .i_cmd        (cmd[g]),
            .i_app_key    (r_key),
            .i_repl       (r_repl),
            .i_next_value (next_value),
            .o_value      (value[g]),
            .o_match      (match[g])
        );
    end

    ovlt_pick #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_pick (
        .i_match (match),
        .o_first (first),
        .o_after (after),
        .o_any   (any),
        .o_pos   (pos)
    );

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cmd[i].write_key  = exec && (r_kind == KIND_APPEND) && !full
                                && (r_count == CW'(i));
            cmd[i].write_repl = exec && (r_kind == KIND_UPDATE) && hit && first[i];
            cmd[i].shift      = exec && (r_kind == KIND_DELETE) && hit && after[i];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_result = r_result;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state                 = ST_IDLE;
                n_result.status         = STAT_OK;
                n_result.found_position = '0;
                if (r_kind == KIND_APPEND) begin
                    if (full) begin
                        n_result.status = STAT_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end else if (r_count == '0) begin
                    n_result.status = STAT_EMPTY;
                end else if (!any) begin
                    n_result.status = STAT_NOT_FOUND;
                end else if (r_kind == KIND_DELETE) begin
                    n_count = r_count - CW'(1);
                end else if (r_kind == KIND_SEARCH) begin
                    n_result.found_position = 8'(pos);
                end
                n_result.entry_count = 9'(n_count);
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= exec;
        end
    end

    // hold the transaction for the execute cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_item.kind;
            r_key  <= i_item.key_value;
            r_repl <= i_item.replacement;
        end
        r_result <= n_result;
    end

    assign busy     = (r_state == ST_EXEC);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hw/rtl/ovlt_cell.sv -----
// ----------------------------------------------------------------------------
// ovlt_cell
// One table entry: holds a value, compares it against the key of a new
// transaction and loads a new value from the key, the replacement or the
// next cell.
// ----------------------------------------------------------------------------
module ovlt_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                i_clk,
    input  logic                i_cmp_en,
    input  logic [31:0]         i_key,
    input  logic [CW-1:0]       i_count,
    input  ovlt_pkg::t_cell_cmd i_cmd,
    input  logic [31:0]         i_app_key,
    input  logic [31:0]         i_repl,
    input  logic [31:0]         i_next_value,
    output logic [31:0]         o_value,
    output logic                o_match
);
    import ovlt_pkg::*;

    logic [31:0] r_value;
    logic        r_match;
    logic        in_range;

    assign in_range = CW'(IDX) < i_count;

    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_match <= in_range && (r_value == i_key);
        end
        if (i_cmd.write_key) begin
            r_value <= i_app_key;
        end else if (i_cmd.write_repl) begin
            r_value <= i_repl;
        end else if (i_cmd.shift) begin
            r_value <= i_next_value;
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

// ----- hw/rtl/ovlt_pick.sv -----
// ----------------------------------------------------------------------------
// ovlt_pick
// First-match selection over the row of cell match flags: one-hot of the
// first match, mask of cells at or after it, and its position.
// ----------------------------------------------------------------------------
module ovlt_pick #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic [DEPTH-1:0] i_match,
    output logic [DEPTH-1:0] o_first,
    output logic [DEPTH-1:0] o_after,
    output logic             o_any,
    output logic [IW-1:0]    o_pos
);
    import ovlt_pkg::*;

    logic [DEPTH-1:0] upto;

    // bits from zero up to and including the lowest set bit
    assign upto    = i_match ^ (i_match - DEPTH'(1));
    assign o_first = upto & i_match;
    assign o_after = ~upto | o_first;
    assign o_any   = |i_match;

    always_comb begin
        o_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (o_first[i]) begin
                o_pos = o_pos | IW'(i);
            end
        end
    end

endmodule

// ----- hw/rtl/ovlt_chk.sv -----
// ----------------------------------------------------------------------------
// ovlt_chk
// Port-level checks for the ordered value list table unit.
// ----------------------------------------------------------------------------
module ovlt_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input ovlt_pkg::t_out o_result
);
    import ovlt_pkg::*;

    // an accepted transaction makes the unit busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not raise busy");

    // the busy cycle is followed by a result, with the unit free again
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("busy cycle not followed by a result");

    // a result never appears without a transaction just before it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a transaction");

    // an empty status always reports no entries
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == STAT_EMPTY) |-> (o_result.entry_count == 9'd0))
        else $error("empty status with nonzero entry count");

    // position is zero on any failed operation
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != STAT_OK) |-> (o_result.found_position == 8'd0))
        else $error("position set on a failed operation");

endmodule

bind ordered_value_list_table_unit ovlt_chk u_ovlt_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered value list table. A behavioral list
// model predicts status, match position and entry count for every accepted
// transaction; each result strobe is checked against the oldest prediction.
// Directed tests cover the empty list, extreme values and a full table, and
// a long random run swings between filling and draining the table.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ovlt_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_OPS  = 1250;
    localparam int STALL_LIMIT = 2000;
    localparam int POOL_SIZE   = 12;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_in   i_item  = '0;
    logic  busy;
    logic  o_valid;
    t_out  o_result;

    ordered_value_list_table_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial forever #5 i_clk = ~i_clk;

    // list model state
    logic [31:0] list_vals [DEPTH];
    int unsigned list_len = 0;

    t_out        pending_results [$];
    t_out        expected_r;
    int          fail_count   = 0;
    int          stall_cycles = 0;
    bit          calm         = 1'b0;
    logic [31:0] key_pool [POOL_SIZE];

    // Apply one operation to the list model and return its result.
    function automatic t_out apply_list_op(t_in op);
        t_out r;
        int   hit;
        r   = '0;
        hit = -1;
        for (int i = 0; i < list_len; i++) begin
            if (hit < 0 && list_vals[i] == op.key_value) hit = i;
        end
        if (op.kind == KIND_APPEND) begin
            if (list_len >= DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                list_vals[list_len] = op.key_value;
                list_len++;
            end
        end else if (list_len == 0) begin
            r.status = STAT_EMPTY;
        end else if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
        end else begin
            case (op.kind)
                KIND_DELETE: begin
                    // close the gap behind the removed entry
                    for (int i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
                    list_len--;
                end
                KIND_SEARCH: r.found_position = 8'(hit);
                default:     list_vals[hit] = op.replacement;
            endcase
        end
        r.entry_count = 9'(list_len);
        return r;
    endfunction

    function automatic t_in make_op(logic [1:0] kind, logic [31:0] key, logic [31:0] repl);
        t_in op;
        op.kind        = kind;
        op.key_value   = key;
        op.replacement = repl;
        return op;
    endfunction

    // Mostly keys that are stored or likely to be, some fully random.
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 45 && list_len > 0) return list_vals[$urandom_range(list_len - 1)];
        if (r < 80) return key_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Send one transaction; start stays high between back-to-back items.
    task automatic send_op(input t_in op);
        int   gap;
        t_out predicted;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 13) gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= op;
        do @(posedge i_clk); while (busy);
        predicted       = apply_list_op(op);
        pending_results = {pending_results, predicted};
    endtask

    task automatic test_empty_list();
        send_op(make_op(KIND_SEARCH, 32'h0000_0000, 32'h0000_0000));
        send_op(make_op(KIND_DELETE, 32'hFFFF_FFFF, 32'h0000_0000));
        send_op(make_op(KIND_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF));
    endtask

    task automatic test_extremes();
        send_op(make_op(KIND_APPEND, 32'h8000_0000, 32'h0000_0000));
        send_op(make_op(KIND_APPEND, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_op(make_op(KIND_APPEND, 32'h0000_0000, 32'h0000_0000));
        send_op(make_op(KIND_APPEND, 32'hFFFF_FFFF, 32'h8000_0000));
        send_op(make_op(KIND_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000));
        send_op(make_op(KIND_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000));
        send_op(make_op(KIND_SEARCH, 32'h0000_0001, 32'h0000_0000));
        send_op(make_op(KIND_UPDATE, 32'h0000_0000, 32'h5555_5555));
        send_op(make_op(KIND_DELETE, 32'h7FFF_FFFF, 32'h0000_0000));
        send_op(make_op(KIND_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000));
        send_op(make_op(KIND_DELETE, 32'h8000_0000, 32'h0000_0000));
    endtask

    // Fill with duplicates in the mix, then hit the full table.
    task automatic test_full_table();
        for (int i = 0; i < DEPTH - 2; i++) begin
            send_op(make_op(KIND_APPEND, (i % 3 == 1) ? 32'hAAAA_AAAA : $urandom, $urandom));
        end
        send_op(make_op(KIND_APPEND, 32'h1234_5678, 32'h0000_0000));
        send_op(make_op(KIND_DELETE, 32'hAAAA_AAAA, 32'h0000_0000));
        send_op(make_op(KIND_SEARCH, 32'hAAAA_AAAA, 32'h0000_0000));
    endtask

    task automatic test_random_ops();
        bit          fill;
        int          k;
        logic [1:0]  kind;
        logic [31:0] repl;
        fill = 1'b0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            // hold the sender busy through the middle stretch
            calm = (n >= 500 && n < 750);
            if ($urandom_range(59) == 0) fill = !fill;
            if ($urandom_range(19) == 0) key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
            k = $urandom_range(99);
            if (k < (fill ? 55 : 20))      kind = KIND_APPEND;
            else if (k < (fill ? 70 : 65)) kind = KIND_DELETE;
            else if (k < 85)               kind = KIND_SEARCH;
            else                           kind = KIND_UPDATE;
            repl = ($urandom_range(3) == 0) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
            send_op(make_op(kind, pick_key(), repl));
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result status=%0d pos=%0d count=%0d",
                    o_result.status, o_result.found_position, o_result.entry_count));
            end else begin
                expected_r = pending_results.pop_front();
                if (o_result.status !== expected_r.status
                        || o_result.found_position !== expected_r.found_position
                        || o_result.entry_count !== expected_r.entry_count) begin
                    note_failure($sformatf(
                        "exp status=%0d pos=%0d count=%0d, got status=%0d pos=%0d count=%0d",
                        expected_r.status, expected_r.found_position, expected_r.entry_count,
                        o_result.status, o_result.found_position, o_result.entry_count));
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_extremes();
        test_full_table();
        test_random_ops();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/ovlt_pkg.sv
hw/rtl/ovlt_cell.sv
hw/rtl/ovlt_pick.sv
hw/rtl/ordered_value_list_table_unit.sv
hw/rtl/ovlt_chk.sv
tb/sv/tb_top.sv
